/* sv/checksummed_settings_store_core_assert.svh */
// ----------------------------------------------------------------------------
// checksummed settings store assertion macros
// shared property forms for the settings store checks
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_SETTINGS_STORE_CORE_ASSERT_SVH
`define CHECKSUMMED_SETTINGS_STORE_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("settings store check failed");

// next-cycle implication, disabled in reset
`define CSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("settings store check failed");

`endif

/* sv/css_pkg.sv */
// ----------------------------------------------------------------------------
// css_pkg
// shared constants, types and helpers for the settings store
// ----------------------------------------------------------------------------
package css_pkg;

    localparam int STORE_BYTES = 1024;
    localparam int ADDR_W      = (STORE_BYTES > 2) ? $clog2(STORE_BYTES) : 1;
    localparam int SUM_W       = 18;
    localparam logic [SUM_W-1:0] STORE_BYTES_S = SUM_W'(STORE_BYTES);
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        MODE_READ      = 3'd0,
        MODE_WRITE     = 3'd1,
        MODE_BSTORE    = 3'd2,
        MODE_BLOAD     = 3'd3,
        MODE_SFINISH   = 3'd4,
        MODE_LFINISH   = 3'd5,
        MODE_CLR_DIRTY = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
    } t_status;

    // rotate left by one, then add
    function automatic logic [7:0] csum_step(input logic [7:0] c, input logic [7:0] v);
        logic [7:0] rot;
        rot = {c[6:0], c[7]};
        return rot + v;
    endfunction

endpackage

/* sv/css_if.sv */
// ----------------------------------------------------------------------------
// css_if
// request and response channels of the settings store
// ----------------------------------------------------------------------------
interface css_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [15:0] address;
    logic [15:0] block_len;
    logic [15:0] block_offset;
    logic [7:0]  data_byte;

    modport source (output valid, mode, address, block_len, block_offset, data_byte,
                    input ready);
    modport sink   (input valid, mode, address, block_len, block_offset, data_byte,
                    output ready);
endinterface

interface css_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       checksum_ok;
    logic       rejected;
    logic       dirty;
    logic       host_notify;

    modport source (output valid, read_data, checksum_ok, rejected, dirty, host_notify,
                    input ready);
    modport sink   (input valid, read_data, checksum_ok, rejected, dirty, host_notify,
                    output ready);
endinterface

/* sv/css_ctrl.sv */
// ----------------------------------------------------------------------------
// css_ctrl
// sequencer: erase pass, request accept, execute and result handoff
// ----------------------------------------------------------------------------
module css_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  css_pkg::t_status  i_status,
    output css_pkg::t_cmd     o_cmd
);

    css_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            accept;
    logic            out_free;
    logic            exec_fire;

    assign o_in_ready = (r_state == css_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign exec_fire  = (r_state == css_pkg::ST_EXEC) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            css_pkg::ST_CLEAR: begin
                if (i_status.clear_last) n_state = css_pkg::ST_IDLE;
            end
            css_pkg::ST_IDLE: begin
                if (accept) n_state = css_pkg::ST_EXEC;
            end
            css_pkg::ST_EXEC: begin
                if (out_free) n_state = css_pkg::ST_IDLE;
            end
            default: begin
                n_state = css_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (exec_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= css_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cmd.clear_wr = (r_state == css_pkg::ST_CLEAR);
    assign o_cmd.capture  = accept;
    assign o_cmd.exec     = exec_fire;

endmodule

/* sv/css_dp.sv */
// ----------------------------------------------------------------------------
// css_dp
// byte memory, range checks, checksum and flag registers, result register
// ----------------------------------------------------------------------------
module css_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  css_pkg::t_cmd     i_cmd,
    output css_pkg::t_status  o_status,
    input  logic [2:0]        i_mode,
    input  logic [15:0]       i_address,
    input  logic [15:0]       i_block_len,
    input  logic [15:0]       i_block_offset,
    input  logic [7:0]        i_data_byte,
    output logic [7:0]        o_read_data,
    output logic              o_checksum_ok,
    output logic              o_rejected,
    output logic              o_dirty,
    output logic              o_host_notify
);

    localparam int AW = css_pkg::ADDR_W;
    localparam int SW = css_pkg::SUM_W;

    logic [7:0]    r_mem [css_pkg::STORE_BYTES];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_clr_cnt;

    // captured request
    css_pkg::t_mode r_mode;
    logic [7:0]     r_data;
    logic [AW-1:0]  r_waddr;
    logic           r_addr_ok;
    logic           r_fits;
    logic           r_off_ok;
    logic           r_off_zero;
    logic           r_len_zero;

    // block and host state
    logic [7:0]     r_csum, n_csum;
    logic           r_changed, n_changed;
    logic           r_dirty, n_dirty;

    // result register
    logic [7:0]     r_read_data;
    logic           r_checksum_ok;
    logic           r_rejected;
    logic           r_out_dirty;
    logic           r_host_notify;

    logic [SW-1:0]  addr_s, len_s, off_s;
    logic [SW-1:0]  end_s;
    logic [SW-1:0]  raddr_s;
    logic           addr_ok, fits, off_ok;
    css_pkg::t_mode in_mode;
    logic [AW-1:0]  raddr;

    logic [7:0]     cs_base, fin_c;
    logic           chg_base;
    logic           x_we;
    logic [7:0]     x_wd, x_rd;
    logic           x_ok, x_rej, x_ntf;

    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [7:0]     mem_wd;

    // range checks on the incoming request
    assign in_mode = css_pkg::t_mode'(i_mode);
    assign addr_s  = SW'(i_address);
    assign len_s   = SW'(i_block_len);
    assign off_s   = SW'(i_block_offset);
    assign end_s   = addr_s + len_s + SW'(1);
    assign addr_ok = addr_s < css_pkg::STORE_BYTES_S;
    assign fits    = addr_ok && (len_s < css_pkg::STORE_BYTES_S)
                     && (end_s <= css_pkg::STORE_BYTES_S);
    assign off_ok  = off_s < len_s;

    always_comb begin
        case (in_mode)
            css_pkg::MODE_BSTORE,
            css_pkg::MODE_BLOAD:   raddr_s = addr_s + off_s;
            css_pkg::MODE_SFINISH,
            css_pkg::MODE_LFINISH: raddr_s = addr_s + len_s;
            default:               raddr_s = addr_s;
        endcase
    end
    assign raddr = raddr_s[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode     <= in_mode;
            r_data     <= i_data_byte;
            r_waddr    <= raddr;
            r_addr_ok  <= addr_ok;
            r_fits     <= fits;
            r_off_ok   <= off_ok;
            r_off_zero <= (i_block_offset == 16'd0);
            r_len_zero <= (i_block_len == 16'd0);
        end
    end

    // execute the captured request against the fetched byte
    always_comb begin
        cs_base   = r_off_zero ? 8'd0 : r_csum;
        chg_base  = r_off_zero ? 1'b0 : r_changed;
        fin_c     = r_len_zero ? 8'd0 : r_csum;
        n_csum    = r_csum;
        n_changed = r_changed;
        n_dirty   = r_dirty;
        x_we      = 1'b0;
        x_wd      = r_data;
        x_rd      = 8'd0;
        x_ok      = 1'b0;
        x_rej     = 1'b0;
        x_ntf     = 1'b0;
        case (r_mode)
            css_pkg::MODE_READ: begin
                if (r_addr_ok) begin
                    x_rd = r_rdata;
                end else begin
                    x_rd  = css_pkg::ERASED_BYTE;
                    x_rej = 1'b1;
                end
            end
            css_pkg::MODE_WRITE: begin
                if (!r_addr_ok) begin
                    x_rej = 1'b1;
                end else if (r_rdata != r_data) begin
                    x_we    = 1'b1;
                    n_dirty = 1'b1;
                    x_ntf   = 1'b1;
                end
            end
            css_pkg::MODE_BSTORE: begin
                if (!(r_fits && r_off_ok)) begin
                    x_rej = 1'b1;
                end else begin
                    n_csum    = css_pkg::csum_step(cs_base, r_data);
                    n_changed = chg_base;
                    if (r_rdata != r_data) begin
                        x_we      = 1'b1;
                        n_changed = 1'b1;
                    end
                end
            end
            css_pkg::MODE_BLOAD: begin
                if (!(r_fits && r_off_ok)) begin
                    x_rej = 1'b1;
                    x_rd  = css_pkg::ERASED_BYTE;
                end else begin
                    x_rd      = r_rdata;
                    n_csum    = css_pkg::csum_step(cs_base, r_rdata);
                    n_changed = chg_base;
                end
            end
            css_pkg::MODE_SFINISH: begin
                if (!r_fits) begin
                    x_rej = 1'b1;
                end else begin
                    x_wd      = fin_c;
                    x_we      = (r_rdata != fin_c);
                    n_changed = 1'b0;
                    if (r_changed || x_we) begin
                        n_dirty = 1'b1;
                        x_ntf   = 1'b1;
                    end
                end
            end
            css_pkg::MODE_LFINISH: begin
                if (!r_fits) begin
                    x_rej = 1'b1;
                end else begin
                    x_ok = (r_rdata == fin_c);
                end
            end
            css_pkg::MODE_CLR_DIRTY: begin
                n_dirty = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // single write port shared by the erase pass and execution
    assign mem_we = i_cmd.clear_wr || (i_cmd.exec && x_we);
    assign mem_wa = i_cmd.clear_wr ? r_clr_cnt : r_waddr;
    assign mem_wd = i_cmd.clear_wr ? css_pkg::ERASED_BYTE : x_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (i_cmd.capture) r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear_wr) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    assign o_status.clear_last = (r_clr_cnt == AW'(css_pkg::STORE_BYTES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_csum    <= 8'd0;
            r_changed <= 1'b0;
            r_dirty   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_csum    <= n_csum;
            r_changed <= n_changed;
            r_dirty   <= n_dirty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_read_data   <= x_rd;
            r_checksum_ok <= x_ok;
            r_rejected    <= x_rej;
            r_out_dirty   <= n_dirty;
            r_host_notify <= x_ntf;
        end
    end

    assign o_read_data   = r_read_data;
    assign o_checksum_ok = r_checksum_ok;
    assign o_rejected    = r_rejected;
    assign o_dirty       = r_out_dirty;
    assign o_host_notify = r_host_notify;

endmodule

/* sv/checksummed_settings_store_core.sv */
// ----------------------------------------------------------------------------
// checksummed_settings_store_core
// byte settings store with streamed checksummed block store and load
// ----------------------------------------------------------------------------
// Each request is handled in two steps: the accept edge launches the read of the
// single-port byte memory, and the execute edge, once the response register is
// free, compares, writes back and loads the response register; the next request
// is taken the cycle after. A held response stalls execution until it is taken.
// After reset the core erases the whole memory to 0xFF, one byte a cycle
// (STORE_BYTES = 1024 bytes), and accepts no request during that pass.
`include "checksummed_settings_store_core_assert.svh"

module checksummed_settings_store_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    css_in_if.sink         i_in,
    css_out_if.source      o_out
);

    css_pkg::t_cmd    cmd;
    css_pkg::t_status status;

    css_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    css_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_mode         (i_in.mode),
        .i_address      (i_in.address),
        .i_block_len    (i_in.block_len),
        .i_block_offset (i_in.block_offset),
        .i_data_byte    (i_in.data_byte),
        .o_read_data    (o_out.read_data),
        .o_checksum_ok  (o_out.checksum_ok),
        .o_rejected     (o_out.rejected),
        .o_dirty        (o_out.dirty),
        .o_host_notify  (o_out.host_notify)
    );

    // one request in flight at a time
    `CSS_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    // a doorbell always comes with the dirty flag set
    `CSS_ASSERT_NOW(a_notify_dirty, i_clk, i_rst_n, o_out.valid && o_out.host_notify, o_out.dirty)
    // a rejected request never reports a good checksum
    `CSS_ASSERT_NOW(a_rej_no_ok, i_clk, i_rst_n, o_out.valid && o_out.rejected, !o_out.checksum_ok)

endmodule

/* tb/settings_store_checker.sv */
// ----------------------------------------------------------------------------
// settings_store_checker
// watches the request and response channels of the settings store, keeps a
// shadow copy of the byte store and its block checksum, and compares every
// response beat field by field against the predicted one
// ----------------------------------------------------------------------------
module settings_store_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    css_in_if    i_req,
    css_out_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] read_data;
        logic       checksum_ok;
        logic       rejected;
        logic       dirty;
        logic       host_notify;
    } t_store_reply;

    logic [7:0]   shadow_bytes [css_pkg::STORE_BYTES];
    logic [7:0]   block_sum;
    logic         block_touched;
    logic         dirty_mirror;
    t_store_reply expected_replies [$];
    int           errors = 0;

    function automatic logic [7:0] rotate_add(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] spun;
        spun = (acc << 1) | (acc >> 7);
        return spun + b;
    endfunction

    function automatic bit block_in_range(input int start, input int len);
        return (start < css_pkg::STORE_BYTES) && (len < css_pkg::STORE_BYTES)
               && (start + len + 1 <= css_pkg::STORE_BYTES);
    endfunction

    function automatic t_store_reply predict_reply(input logic [2:0] mode, input int addr,
                                                   input int len, input int off,
                                                   input logic [7:0] data);
        t_store_reply r;
        logic [7:0]   sum;
        logic         changed;
        r = '0;
        case (mode)
            css_pkg::MODE_READ: begin
                if (addr < css_pkg::STORE_BYTES) begin
                    r.read_data = shadow_bytes[addr];
                end else begin
                    r.read_data = css_pkg::ERASED_BYTE;
                    r.rejected  = 1'b1;
                end
            end
            css_pkg::MODE_WRITE: begin
                if (addr >= css_pkg::STORE_BYTES) begin
                    r.rejected = 1'b1;
                end else if (shadow_bytes[addr] != data) begin
                    shadow_bytes[addr] = data;
                    dirty_mirror       = 1'b1;
                    r.host_notify      = 1'b1;
                end
            end
            css_pkg::MODE_BSTORE, css_pkg::MODE_BLOAD: begin
                if (!block_in_range(addr, len) || off >= len) begin
                    r.rejected = 1'b1;
                    if (mode == css_pkg::MODE_BLOAD) r.read_data = css_pkg::ERASED_BYTE;
                end else begin
                    // first byte of a block restarts the running sum
                    if (off == 0) begin
                        block_sum     = '0;
                        block_touched = 1'b0;
                    end
                    if (mode == css_pkg::MODE_BSTORE) begin
                        block_sum = rotate_add(block_sum, data);
                        if (shadow_bytes[addr + off] != data) begin
                            shadow_bytes[addr + off] = data;
                            block_touched            = 1'b1;
                        end
                    end else begin
                        r.read_data = shadow_bytes[addr + off];
                        block_sum   = rotate_add(block_sum, r.read_data);
                    end
                end
            end
            css_pkg::MODE_SFINISH, css_pkg::MODE_LFINISH: begin
                if (!block_in_range(addr, len)) begin
                    r.rejected = 1'b1;
                end else begin
                    sum = (len == 0) ? 8'h00 : block_sum;
                    if (mode == css_pkg::MODE_SFINISH) begin
                        changed = block_touched;
                        if (shadow_bytes[addr + len] != sum) begin
                            shadow_bytes[addr + len] = sum;
                            changed                  = 1'b1;
                        end
                        if (changed) begin
                            dirty_mirror  = 1'b1;
                            r.host_notify = 1'b1;
                        end
                        block_touched = 1'b0;
                    end else begin
                        r.checksum_ok = (shadow_bytes[addr + len] == sum);
                    end
                end
            end
            css_pkg::MODE_CLR_DIRTY: begin
                dirty_mirror = 1'b0;
            end
            default: begin
            end
        endcase
        r.dirty = dirty_mirror;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_store_reply want;
        t_store_reply got;
        if (!i_rst_n) begin
            foreach (shadow_bytes[i]) shadow_bytes[i] = css_pkg::ERASED_BYTE;
            block_sum     = '0;
            block_touched = 1'b0;
            dirty_mirror  = 1'b0;
            expected_replies.delete();
        end else begin
            // response side first so a beat is never matched to a request of this edge
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.read_data, i_rsp.checksum_ok, i_rsp.rejected, i_rsp.dirty,
                        i_rsp.host_notify};
                if (expected_replies.size() == 0) begin
                    errors++;
                    $display("%0t: response beat with none expected, expected none, got %0h",
                             $time, got);
                end else begin
                    want = expected_replies.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("checksum_ok", 8'(want.checksum_ok), 8'(got.checksum_ok));
                    check_field("rejected", 8'(want.rejected), 8'(got.rejected));
                    check_field("dirty", 8'(want.dirty), 8'(got.dirty));
                    check_field("host_notify", 8'(want.host_notify), 8'(got.host_notify));
                end
            end
            if (i_req.valid && i_req.ready)
                expected_replies.push_back(predict_reply(i_req.mode, int'(i_req.address),
                                                         int'(i_req.block_len),
                                                         int'(i_req.block_offset),
                                                         i_req.data_byte));
        end
        o_fail_count <= errors;
        o_pending    <= expected_replies.size();
    end

endmodule

/* tb/tb_checksummed_settings_store_core.sv */
// ----------------------------------------------------------------------------
// tb_checksummed_settings_store_core
// drives directed and random requests into the settings store with random
// gaps and back-pressure, and reports the verdict of the checker
// ----------------------------------------------------------------------------
module tb_checksummed_settings_store_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_UNUSED  = 3'd7;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         RANDOM_ITEMS = 1425;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   sender_idle_pct = 29;
    int   rcv_idle_pct    = 65;
    int   hold_trigger    = 0;
    int   items_sent      = 0;
    int   cycle_count     = 0;
    int   recent_addr [4] = '{100, 0, 0, 0};
    int   recent_len  [4] = '{3, 0, 0, 0};
    int   recent_wr       = 1;

    css_in_if  in_ch ();
    css_out_if out_ch ();

    checksummed_settings_store_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    settings_store_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (in_ch),
        .i_rsp        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // response side: random stalls, plus one long hold-off on request
    initial begin : response_ready
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_trigger != hold_seen) begin
                hold_seen = hold_trigger;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("checksummed_settings_store_core: mismatch");
        $finish;
    end

    task automatic offer(input logic [2:0] mode, input logic [15:0] addr, len, off,
                         input logic [7:0] data);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= mode;
        in_ch.address      <= addr;
        in_ch.block_len    <= len;
        in_ch.block_offset <= off;
        in_ch.data_byte    <= data;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (mode != MODE_UNUSED) items_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // bias toward the erased value and zero so unchanged writes show up
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(5);
        if (r == 0) return 8'h00;
        if (r == 1) return css_pkg::ERASED_BYTE;
        return 8'($urandom);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 2) return 0;
        if (r < 92) return $urandom_range(12, 1);
        return $urandom_range(80, 13);
    endfunction

    task automatic directed_items();
        offer(css_pkg::MODE_READ, 16'd0, 16'd0, 16'd0, 8'h00);
        offer(css_pkg::MODE_READ, 16'd1023, 16'd0, 16'd0, 8'h00);
        offer(css_pkg::MODE_READ, 16'd1024, 16'd0, 16'd0, 8'h00);
        offer(css_pkg::MODE_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        offer(css_pkg::MODE_WRITE, 16'd0, 16'd0, 16'd0, 8'h00);
        // same byte again: no change, no doorbell
        offer(css_pkg::MODE_WRITE, 16'd0, 16'd0, 16'd0, 8'h00);
        offer(css_pkg::MODE_WRITE, 16'd1023, 16'd0, 16'd0, 8'h5A);
        offer(css_pkg::MODE_WRITE, 16'hFFFF, 16'd0, 16'd0, 8'h12);
        offer(css_pkg::MODE_CLR_DIRTY, 16'd0, 16'd0, 16'd0, 8'h00);
        offer(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        offer(css_pkg::MODE_BSTORE, 16'd100, 16'd3, 16'd0, 8'hFF);
        offer(css_pkg::MODE_BSTORE, 16'd100, 16'd3, 16'd1, 8'h01);
        offer(css_pkg::MODE_BSTORE, 16'd100, 16'd3, 16'd2, 8'h80);
        offer(css_pkg::MODE_SFINISH, 16'd100, 16'd3, 16'hFFFF, 8'h00);
        offer(css_pkg::MODE_BLOAD, 16'd100, 16'd3, 16'd0, 8'h00);
        offer(css_pkg::MODE_BLOAD, 16'd100, 16'd3, 16'd1, 8'h00);
        offer(css_pkg::MODE_BLOAD, 16'd100, 16'd3, 16'd2, 8'h00);
        offer(css_pkg::MODE_LFINISH, 16'd100, 16'd3, 16'd0, 8'h00);
        offer(css_pkg::MODE_WRITE, 16'd101, 16'd0, 16'd0, 8'h00);
        offer(css_pkg::MODE_LFINISH, 16'd100, 16'd3, 16'd0, 8'h00);
        // empty block: checksum taken as zero
        offer(css_pkg::MODE_SFINISH, 16'd200, 16'd0, 16'd0, 8'h00);
        offer(css_pkg::MODE_LFINISH, 16'd200, 16'd0, 16'd0, 8'h00);
        offer(css_pkg::MODE_BSTORE, 16'd5, 16'd2, 16'd2, 8'h33);
        offer(css_pkg::MODE_BLOAD, 16'd1000, 16'd24, 16'd0, 8'h00);
        offer(css_pkg::MODE_SFINISH, 16'd0, 16'd1023, 16'd0, 8'h00);
        offer(css_pkg::MODE_SFINISH, 16'd1, 16'd1023, 16'd0, 8'h00);
    endtask

    task automatic store_run(input int start, input int len);
        for (int k = 0; k < len; k++)
            offer(css_pkg::MODE_BSTORE, 16'(start), 16'(len), 16'(k), pick_byte());
        offer(css_pkg::MODE_SFINISH, 16'(start), 16'(len), 16'($urandom), 8'($urandom));
    endtask

    task automatic random_traffic(input int target);
        int pick;
        int start;
        int len;
        int slot;
        logic [2:0] m;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                len   = pick_len();
                start = $urandom_range(css_pkg::STORE_BYTES - 1 - len);
                store_run(start, len);
                recent_addr[recent_wr] = start;
                recent_len[recent_wr]  = len;
                recent_wr              = (recent_wr + 1) % 4;
            end else if (pick < 55) begin
                slot  = $urandom_range(3);
                start = recent_addr[slot];
                len   = recent_len[slot];
                // now and then spoil one byte so the checksum compare can fail
                if (len > 0 && $urandom_range(9) == 0)
                    offer(css_pkg::MODE_WRITE, 16'(start + $urandom_range(len - 1)),
                          16'($urandom), 16'($urandom), 8'($urandom));
                for (int k = 0; k < len; k++)
                    offer(css_pkg::MODE_BLOAD, 16'(start), 16'(len), 16'(k), 8'($urandom));
                offer(css_pkg::MODE_LFINISH, 16'(start), 16'(len), 16'($urandom),
                      8'($urandom));
            end else if (pick < 63) begin
                // broken block: late start, skipped bytes, finish optional
                len   = pick_len() + 1;
                start = $urandom_range(css_pkg::STORE_BYTES - 1 - len);
                m     = $urandom_range(1) ? css_pkg::MODE_BSTORE : css_pkg::MODE_BLOAD;
                for (int k = $urandom_range(len - 1); k < len; k += $urandom_range(2, 1))
                    offer(m, 16'(start), 16'(len), 16'(k), pick_byte());
                if ($urandom_range(1))
                    offer($urandom_range(1) ? css_pkg::MODE_SFINISH : css_pkg::MODE_LFINISH,
                          16'(start), 16'(len), 16'($urandom), 8'($urandom));
            end else if (pick < 83) begin
                start = ($urandom_range(4) == 0) ? $urandom_range(16'hFFFF)
                                                 : $urandom_range(css_pkg::STORE_BYTES - 1);
                offer($urandom_range(1) ? css_pkg::MODE_WRITE : css_pkg::MODE_READ,
                      16'(start), 16'($urandom), 16'($urandom), pick_byte());
            end else if (pick < 90) begin
                offer(css_pkg::MODE_CLR_DIRTY, 16'($urandom), 16'($urandom), 16'($urandom),
                      8'($urandom));
            end else if (pick < 93) begin
                offer(MODE_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                      8'($urandom));
            end else begin
                m = 3'($urandom_range(css_pkg::MODE_LFINISH, css_pkg::MODE_BSTORE));
                offer(m, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        in_ch.valid        <= 1'b0;
        in_ch.mode         <= css_pkg::MODE_READ;
        in_ch.address      <= '0;
        in_ch.block_len    <= '0;
        in_ch.block_offset <= '0;
        in_ch.data_byte    <= '0;
        i_rst_n            <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_items();
        random_traffic(items_sent + RANDOM_ITEMS / 3);
        wait_drained();

        sender_idle_pct = 65;
        rcv_idle_pct    = 29;
        random_traffic(items_sent + RANDOM_ITEMS / 3);
        wait_drained();

        sender_idle_pct = 0;
        rcv_idle_pct    = 0;
        random_traffic(items_sent + RANDOM_ITEMS / 6);
        // long response stall while requests keep coming
        hold_trigger++;
        random_traffic(items_sent + RANDOM_ITEMS / 6);
        in_ch.valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("checksummed_settings_store_core: match");
        else
            $display("checksummed_settings_store_core: mismatch");
        $finish;
    end

endmodule
